// File: rtl/core/brbs_pkg.sv
// Package for the 1-bpp bitmap row scaler.
// Holds the channel and register constants, step-unit opcodes and the result
// structs. No dependencies.
package brbs_pkg;

  // Channel payload widths.
  localparam int unsigned SRC_W = 8;
  localparam int unsigned DST_W = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH   = 1'd1;

  // Most significant bit of a packed destination word.
  localparam logic [DST_W-1:0] DST_MSB = 8'h80;

  // Source bits held in one input word, and the width of a count of them.
  localparam int unsigned BITS_PER_WORD = 8;
  localparam int unsigned NBITS_W       = 4;

  // Operations of the shared step unit.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SHRINK,
    OP_GROW,
    OP_REPEAT,
    OP_FLUSH
  } op_e;

  // One result word without its run_last flag.
  typedef struct packed {
    logic [DST_W-1:0] data;
    logic             row_done;
    logic             ratio_error;
  } res_t;

  // Request from the sequencer to the result buffer.
  typedef struct packed {
    logic push;
    logic flush;
    res_t res;
  } res_req_t;

endpackage

// File: rtl/core/brbs_if.sv
// Valid/ready channel interfaces of the 1-bpp bitmap row scaler.
// Input channel carries source words, output channel destination words.
// No dependencies.
interface brbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface

interface brbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] dst_byte;
  logic       run_last;
  logic       row_done;
  logic       ratio_error;

  modport source (output valid, output dst_byte, output run_last, output row_done,
                  output ratio_error, input ready);
  modport sink (input valid, input dst_byte, input run_last, input row_done,
                input ratio_error, output ready);
endinterface

// File: rtl/core/brbs_step_unit.sv
// Shared step unit of the row scaler: one Bresenham error update and at most
// one destination bit advance per cycle. Combinational; depends on brbs_pkg.
module brbs_step_unit #(
  parameter int unsigned CntW = 13
) (
  input  brbs_pkg::op_e       op_i,
  input  logic                bit_i,
  input  logic [CntW-1:0]     sw_i,
  input  logic [CntW-1:0]     dw_i,
  input  logic [CntW:0]       err_i,
  input  logic [CntW-1:0]     dst_i,
  input  logic [2:0]          pos_i,
  input  logic [7:0]          acc_i,
  output logic [CntW:0]       err_o,
  output logic [CntW-1:0]     dst_o,
  output logic [2:0]          pos_o,
  output logic [7:0]          acc_o,
  output logic                more_o,
  output logic                emit_o,
  output brbs_pkg::res_t      emit_res_o
);
  import brbs_pkg::*;

  localparam int unsigned ErrW = CntW + 1;

  logic [ErrW-1:0] sum;
  logic [ErrW-1:0] diff;
  logic            over;
  logic            adv_req;
  logic            or_en;
  logic            adv;
  logic [CntW-1:0] dnext;
  logic            word_end;
  logic [7:0]      acc_or;

  // Error term: add the destination width for shrink and grow, subtract the source width.
  always_comb begin
    sum  = err_i + (((op_i == OP_SHRINK) || (op_i == OP_GROW)) ? ErrW'(dw_i) : '0);
    diff = sum - ErrW'(sw_i);
    over = sum > ErrW'(sw_i);
  end

  // Per-operation selection of the new error term and whether to advance.
  always_comb begin
    case (op_i)
      OP_SHRINK: begin
        err_o   = over ? diff : sum;
        adv_req = over;
        or_en   = 1'b1;
      end
      OP_GROW, OP_REPEAT: begin
        err_o   = diff;
        adv_req = 1'b1;
        or_en   = 1'b1;
      end
      OP_FLUSH: begin
        err_o   = err_i;
        adv_req = 1'b1;
        or_en   = 1'b0;
      end
      default: begin
        err_o   = err_i;
        adv_req = 1'b0;
        or_en   = 1'b0;
      end
    endcase
  end

  // OR the source bit into the open destination bit, then close that bit on an advance.
  always_comb begin
    acc_or   = acc_i | ((or_en && bit_i) ? (DST_MSB >> pos_i) : 8'h00);
    adv      = adv_req && (dst_i < dw_i);
    dnext    = dst_i + CntW'(1);
    word_end = (pos_i == 3'd7) || (dnext == dw_i);

    emit_o              = 1'b0;
    emit_res_o.data     = acc_or;
    emit_res_o.row_done = dnext == dw_i;
    emit_res_o.ratio_error = 1'b0;
    dst_o = dst_i;
    pos_o = pos_i;
    acc_o = acc_or;
    if (adv) begin
      dst_o = dnext;
      if (word_end) begin
        emit_o = 1'b1;
        acc_o  = 8'h00;
        pos_o  = 3'd0;
      end else begin
        pos_o = pos_i + 3'd1;
      end
    end
  end

  // Another repeat of the same source bit is due.
  assign more_o = (err_o >= ErrW'(sw_i)) && (dst_o < dw_i);

endmodule

// File: rtl/core/brbs_result_buf.sv
// Result buffer of the row scaler: one pending word that waits to learn
// whether it ends its run, and the output register. Depends on brbs_pkg, brbs_if.
module brbs_result_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brbs_pkg::res_req_t  req_i,
  output logic                room_o,
  brbs_out_if.source          out_o
);
  import brbs_pkg::*;

  logic pend_v_q, pend_v_d;
  res_t pend_q, pend_d;
  logic out_v_q, out_v_d;
  res_t out_res_q, out_res_d;
  logic out_last_q, out_last_d;
  logic out_free;
  logic move;

  assign out_free = !out_v_q || out_o.ready;
  assign room_o   = !pend_v_q || out_free;
  assign move     = pend_v_q && out_free && (req_i.push || req_i.flush);

  // Pending word and output register updates.
  always_comb begin
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q;
    out_res_d  = out_res_q;
    out_last_d = out_last_q;
    if (req_i.push) begin
      pend_v_d = 1'b1;
      pend_d   = req_i.res;
    end else if (req_i.flush && move) begin
      pend_v_d = 1'b0;
    end
    if (move) begin
      out_v_d    = 1'b1;
      out_res_d  = pend_q;
      out_last_d = req_i.flush;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid       = out_v_q;
  assign out_o.dst_byte    = out_res_q.data;
  assign out_o.row_done    = out_res_q.row_done;
  assign out_o.ratio_error = out_res_q.ratio_error;
  assign out_o.run_last    = out_last_q;

endmodule

// File: rtl/core/bit_row_bresenham_scaler_unit.sv
// Top level of the 1-bpp bitmap row scaler: sequencer, row state and
// configuration registers. Depends on brbs_pkg, brbs_if, brbs_step_unit and
// brbs_result_buf.
//
// Usage: source words (8 pixels, first pixel in the MSB) enter on in_i, a
// row taking ceil(source_width / 8) words. Packed destination words leave on
// out_o, ceil(dest_width / 8) per row; run_last marks the last word caused by
// an input word and row_done the last word of the row. Widths are to be written
// on the configuration port only while the block is idle; the block does not
// enforce this. A write restarts the row. Throughput: one input word at a time.
// The shared step unit handles one source bit per cycle while the result buffer
// has room. A word passes S_IDLE, S_BIT per source bit (up to 8), S_REP per
// extra destination bit when the row grows, S_END and S_FIN; if the growth
// ratio is too large, S_IDLE, S_RATIO and S_FIN, and the word only raises
// ratio_error. A pending register holds a word until it is known whether it
// ends the run. A stalled receiver holds the output register and then the
// sequencer. Reset sets both widths to 8 and clears the row state.
module bit_row_bresenham_scaler_unit #(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_UP_RATIO = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  brbs_in_if.sink                              in_i,
  brbs_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic [brbs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [brbs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import brbs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW = CW + 1;
  localparam int unsigned RW = CW + $clog2(MAX_UP_RATIO + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RATIO = 3'd1;
  localparam logic [2:0] S_BIT   = 3'd2;
  localparam logic [2:0] S_REP   = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      sw_q, sw_d, dw_q, dw_d;
  logic [EW-1:0]      err_q, err_d;
  logic [CW-1:0]      src_q, src_d;
  logic [CW-1:0]      dst_q, dst_d;
  logic [2:0]         pos_q, pos_d;
  logic [7:0]         acc_q, acc_d;
  logic [NBITS_W-1:0] cnt_q, cnt_d;
  logic [7:0]         sh_q, sh_d;
  logic               bit_q, bit_d;

  logic               shrink;
  logic               ratio_err;
  logic               row_end;
  logic [31:0]        cfg_v32;
  logic [CW-1:0]      cfg_w;
  logic [CW-1:0]      base;
  logic [CW-1:0]      rem;
  logic [NBITS_W-1:0] nbits;
  logic               restart;

  op_e                op;
  logic               op_bit;
  logic [EW-1:0]      st_err;
  logic [CW-1:0]      st_dst;
  logic [2:0]         st_pos;
  logic [7:0]         st_acc;
  logic               st_more;
  logic               st_emit;
  res_t               st_res;
  logic               stall;
  logic               room;
  res_req_t           req;

  // Mode flags from the configured widths.
  assign shrink    = sw_q > dw_q;
  assign ratio_err = RW'(dw_q) > (RW'(sw_q) * RW'(MAX_UP_RATIO));
  assign row_end   = src_q >= sw_q;

  // Width clamp for configuration writes: zero reads as one, large as the maximum.
  always_comb begin
    cfg_v32 = 32'(cfg_data_i);
    if (cfg_v32 == 32'd0) begin
      cfg_w = CW'(1);
    end else if (cfg_v32 > 32'(MAX_WIDTH)) begin
      cfg_w = CW'(MAX_WIDTH);
    end else begin
      cfg_w = CW'(cfg_v32);
    end
  end

  // Source bits taken by a new word.
  always_comb begin
    restart = src_q >= sw_q;
    base    = restart ? '0 : src_q;
    rem     = sw_q - base;
    nbits   = (rem > CW'(BITS_PER_WORD)) ? NBITS_W'(BITS_PER_WORD) : rem[NBITS_W-1:0];
  end

  // Operation for the shared step unit.
  always_comb begin
    op     = OP_NONE;
    op_bit = 1'b0;
    case (state_q)
      S_BIT: begin
        op     = shrink ? OP_SHRINK : OP_GROW;
        op_bit = sh_q[7];
      end
      S_REP: begin
        op     = OP_REPEAT;
        op_bit = bit_q;
      end
      S_END: begin
        op = (shrink && row_end) ? OP_FLUSH : OP_NONE;
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  brbs_step_unit #(
    .CntW (CW)
  ) u_step (
    .op_i       (op),
    .bit_i      (op_bit),
    .sw_i       (sw_q),
    .dw_i       (dw_q),
    .err_i      (err_q),
    .dst_i      (dst_q),
    .pos_i      (pos_q),
    .acc_i      (acc_q),
    .err_o      (st_err),
    .dst_o      (st_dst),
    .pos_o      (st_pos),
    .acc_o      (st_acc),
    .more_o     (st_more),
    .emit_o     (st_emit),
    .emit_res_o (st_res)
  );

  assign stall = st_emit && !room;

  // Sequencer and row state.
  always_comb begin
    state_d = state_q;
    sw_d    = sw_q;
    dw_d    = dw_q;
    err_d   = err_q;
    src_d   = src_q;
    dst_d   = dst_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    sh_d    = sh_q;
    bit_d   = bit_q;
    req     = '0;
    req.res = st_res;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          sh_d  = in_i.src_byte;
          cnt_d = nbits;
          if (restart) begin
            err_d = '0;
            dst_d = '0;
            pos_d = '0;
            acc_d = '0;
          end
          if (ratio_err) begin
            src_d   = base + CW'(nbits);
            state_d = S_RATIO;
          end else begin
            src_d   = base;
            state_d = S_BIT;
          end
        end
      end
      S_RATIO: begin
        req.push             = 1'b1;
        req.res.data         = 8'h00;
        req.res.row_done     = row_end;
        req.res.ratio_error  = 1'b1;
        if (row_end) begin
          src_d = '0;
        end
        state_d = S_FIN;
      end
      S_BIT: begin
        if (!stall) begin
          req.push = st_emit;
          err_d    = st_err;
          dst_d    = st_dst;
          pos_d    = st_pos;
          acc_d    = st_acc;
          src_d    = src_q + CW'(1);
          cnt_d    = cnt_q - NBITS_W'(1);
          sh_d     = {sh_q[6:0], 1'b0};
          bit_d    = sh_q[7];
          if (!shrink && st_more) begin
            state_d = S_REP;
          end else if (cnt_q == NBITS_W'(1)) begin
            state_d = S_END;
          end else begin
            state_d = S_BIT;
          end
        end
      end
      S_REP: begin
        if (!stall) begin
          req.push = st_emit;
          err_d    = st_err;
          dst_d    = st_dst;
          pos_d    = st_pos;
          acc_d    = st_acc;
          if (st_more) begin
            state_d = S_REP;
          end else if (cnt_q == '0) begin
            state_d = S_END;
          end else begin
            state_d = S_BIT;
          end
        end
      end
      S_END: begin
        if (!stall) begin
          req.push = st_emit;
          if (row_end) begin
            err_d = '0;
            src_d = '0;
            dst_d = '0;
            pos_d = '0;
            acc_d = '0;
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (room) begin
          req.flush = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Register writes restart the row.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_WIDTH: sw_d = cfg_w;
        CFG_DEST_WIDTH:   dw_d = cfg_w;
        default:          sw_d = sw_q;
      endcase
      err_d = '0;
      src_d = '0;
      dst_d = '0;
      pos_d = '0;
      acc_d = '0;
    end
  end

  assign in_i.ready = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sw_q    <= CW'(8);
      dw_q    <= CW'(8);
      err_q   <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      pos_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sw_q    <= sw_d;
      dw_q    <= dw_d;
      err_q   <= err_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bit_q <= bit_d;
  end

  brbs_result_buf u_res (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
